// ===== sv/gspc_pkg.sv =====
`default_nettype none
package gspc_pkg;

	localparam int ADC_BITS_DEFAULT = 10;
	localparam int REG_W = 16;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_LOAD_RES = 3'd0;
	localparam logic [IDX_W-1:0] REG_CLEAN_RES = 3'd1;
	localparam logic [IDX_W-1:0] REG_LPG_SLOPE = 3'd2;
	localparam logic [IDX_W-1:0] REG_LPG_OFFSET = 3'd3;
	localparam logic [IDX_W-1:0] REG_CO_SLOPE = 3'd4;
	localparam logic [IDX_W-1:0] REG_CO_OFFSET = 3'd5;
	localparam logic [IDX_W-1:0] REG_SMOKE_SLOPE = 3'd6;
	localparam logic [IDX_W-1:0] REG_SMOKE_OFFSET = 3'd7;

	localparam logic [REG_W-1:0] LOAD_RES_RST = 16'd1280;
	localparam logic [REG_W-1:0] CLEAN_RES_RST = 16'd2560;
	localparam logic [REG_W-1:0] LPG_SLOPE_RST = 16'hDDF4;
	localparam logic [REG_W-1:0] LPG_OFFSET_RST = 16'd11251;
	localparam logic [REG_W-1:0] CO_SLOPE_RST = 16'hD0F1;
	localparam logic [REG_W-1:0] CO_OFFSET_RST = 16'd18096;
	localparam logic [REG_W-1:0] SMOKE_SLOPE_RST = 16'hDBA3;
	localparam logic [REG_W-1:0] SMOKE_OFFSET_RST = 16'd14355;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	// Log of one operand: exponent, normalized mantissa and fraction bits so far.
	typedef struct packed {
		logic [4:0] p;
		logic [31:0] m;
		logic [15:0] frac;
	} lg_t;

	typedef struct packed {
		lg_t ln;
		lg_t ld;
		logic n_zero;
		logic d_zero;
	} front_t;

	typedef struct packed {
		logic [30:0] mant;
		logic [3:0] k;
		logic [15:0] f;
		logic sat;
		logic neg;
	} ex_t;

	function automatic logic [4:0] lead_one(input logic [31:0] x);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				r = 5'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v = v_in;
		res = 64'd0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int j = 0; j < 32; j++) begin
			if (b != 64'd0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-i) in Q30, built by repeated square roots.
	function automatic logic [30:0] exp_factor(input int i);
		logic [63:0] c;
		c = isqrt64(64'd1 << 61);
		for (int g = 2; g <= 16; g++) begin
			if (g <= i) begin
				c = isqrt64(c << 30);
			end
		end
		return c[30:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/gas_sensor_ppm_converter_unit.sv =====
// Converts one ADC sample of a tin-oxide gas sensor divider into LPG, CO and
// smoke concentrations in ppm, using the log-curve model with per-gas slope
// and offset registers in Q4.12. A new word is taken every cycle unless
// in_stall is high; the pipeline holds the sixteen squaring stages of the
// log2 unit and the sixteen multiply stages of the power-of-two unit. A stall
// on a valid output word freezes the whole pipeline, bubbles included, so the
// input is held off exactly while the output word waits. The user must write
// configuration only while no word is in flight; the block does not enforce it.
`default_nettype none
module gas_sensor_ppm_converter_unit #(
	parameter int ADC_BITS = gspc_pkg::ADC_BITS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [ADC_BITS-1:0] adc_sample,
	output logic out_valid,
	input wire logic out_stall,
	output logic [15:0] lpg_ppm,
	output logic [15:0] co_ppm,
	output logic [15:0] smoke_ppm,
	output logic [1:0] status,
	input wire logic cfg_we,
	input wire logic [gspc_pkg::IDX_W-1:0] cfg_index,
	input wire logic [gspc_pkg::REG_W-1:0] cfg_data
);

	localparam int NSTAGE = 41;
	localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

	logic [15:0] load_q;
	logic [15:0] clean_q;
	logic [15:0] curve_q [0:5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= gspc_pkg::LOAD_RES_RST;
			clean_q <= gspc_pkg::CLEAN_RES_RST;
			curve_q[0] <= gspc_pkg::LPG_SLOPE_RST;
			curve_q[1] <= gspc_pkg::LPG_OFFSET_RST;
			curve_q[2] <= gspc_pkg::CO_SLOPE_RST;
			curve_q[3] <= gspc_pkg::CO_OFFSET_RST;
			curve_q[4] <= gspc_pkg::SMOKE_SLOPE_RST;
			curve_q[5] <= gspc_pkg::SMOKE_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gspc_pkg::REG_LOAD_RES: load_q <= cfg_data;
				gspc_pkg::REG_CLEAN_RES: clean_q <= cfg_data;
				gspc_pkg::REG_LPG_SLOPE: curve_q[0] <= cfg_data;
				gspc_pkg::REG_LPG_OFFSET: curve_q[1] <= cfg_data;
				gspc_pkg::REG_CO_SLOPE: curve_q[2] <= cfg_data;
				gspc_pkg::REG_CO_OFFSET: curve_q[3] <= cfg_data;
				gspc_pkg::REG_SMOKE_SLOPE: curve_q[4] <= cfg_data;
				gspc_pkg::REG_SMOKE_OFFSET: curve_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] zero_q;

	assign adv = !vld_q[NSTAGE-1] || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTAGE-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_q <= {zero_q[NSTAGE-2:0], (adc_sample == '0)};
		end
	end

	// Stage 1: numerator and denominator of the resistance ratio.
	logic [31:0] n_s1, d_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1 <= 32'(load_q) * 32'(FULL - adc_sample);
			d_s1 <= 32'(adc_sample) * 32'(clean_q);
		end
	end

	// Stage 2: leading-one position.
	logic [31:0] n_s2, d_s2;
	logic [4:0] pn_s2, pd_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s2 <= n_s1;
			d_s2 <= d_s1;
			pn_s2 <= gspc_pkg::lead_one(n_s1);
			pd_s2 <= gspc_pkg::lead_one(d_s1);
		end
	end

	// Stage 3 feeds the squaring chain with normalized Q1.31 mantissas.
	gspc_pkg::front_t sq_s [0:16];
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].ln.p <= pn_s2;
			sq_s[0].ln.m <= n_s2 << (5'd31 - pn_s2);
			sq_s[0].ln.frac <= '0;
			sq_s[0].ld.p <= pd_s2;
			sq_s[0].ld.m <= d_s2 << (5'd31 - pd_s2);
			sq_s[0].ld.frac <= '0;
			sq_s[0].n_zero <= (n_s2 == '0);
			sq_s[0].d_zero <= (d_s2 == '0);
		end
	end

	for (genvar j = 0; j < 16; j++) begin : g_sq
		logic [63:0] sqn, sqd;
		logic [32:0] tn, td;
		gspc_pkg::front_t nx;
		assign sqn = 64'(sq_s[j].ln.m) * 64'(sq_s[j].ln.m);
		assign sqd = 64'(sq_s[j].ld.m) * 64'(sq_s[j].ld.m);
		assign tn = sqn[63:31];
		assign td = sqd[63:31];
		always_comb begin
			nx = sq_s[j];
			nx.ln.m = tn[32] ? tn[32:1] : tn[31:0];
			nx.ln.frac = {sq_s[j].ln.frac[14:0], tn[32]};
			nx.ld.m = td[32] ? td[32:1] : td[31:0];
			nx.ld.frac = {sq_s[j].ld.frac[14:0], td[32]};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[j+1] <= nx;
			end
		end
	end

	// Stage 20: log2 difference scaled by log10(2).
	logic signed [21:0] ldiff;
	logic signed [36:0] prod_s20;
	logic nz_s20, dz_s20;
	assign ldiff = $signed({1'b0, sq_s[16].ln.p, sq_s[16].ln.frac})
		- $signed({1'b0, sq_s[16].ld.p, sq_s[16].ld.frac});
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s20 <= $signed({{15{ldiff[21]}}, ldiff}) * 37'sd19728;
			nz_s20 <= sq_s[16].n_zero;
			dz_s20 <= sq_s[16].d_zero;
		end
	end

	// Stage 21: floor, clamp and the degenerate ratios.
	logic signed [16:0] lsh;
	logic signed [15:0] lq_s21;
	assign lsh = prod_s20[36:20];
	always_ff @(posedge clk) begin
		if (adv) begin
			if (dz_s20) begin
				lq_s21 <= 16'sh7FFF;
			end else if (nz_s20) begin
				lq_s21 <= 16'sh8000;
			end else if (lsh > 17'sd32767) begin
				lq_s21 <= 16'sh7FFF;
			end else if (lsh < -17'sd32768) begin
				lq_s21 <= 16'sh8000;
			end else begin
				lq_s21 <= lsh[15:0];
			end
		end
	end

	logic signed [20:0] e_s22 [0:2];
	logic signed [26:0] t_s23 [0:2];
	gspc_pkg::ex_t ex_s [0:2][0:16];
	logic [15:0] ppm [0:2];
	logic [2:0] sat_g;

	for (genvar g = 0; g < 3; g++) begin : g_gas
		logic signed [31:0] pr;
		logic signed [39:0] te;
		logic signed [26:0] tv;
		assign pr = $signed(lq_s21) * $signed(curve_q[2*g]);
		assign te = $signed({{19{e_s22[g][20]}}, e_s22[g]}) * 40'sd217706;
		assign tv = t_s23[g];

		always_ff @(posedge clk) begin
			if (adv) begin
				e_s22[g] <= $signed({pr[31], pr[31:12]})
					+ $signed({{5{curve_q[2*g+1][15]}}, curve_q[2*g+1]});
				t_s23[g] <= te[38:12];
				ex_s[g][0].mant <= 31'd1 << 30;
				ex_s[g][0].k <= tv[19:16];
				ex_s[g][0].f <= tv[15:0];
				ex_s[g][0].neg <= tv[26];
				ex_s[g][0].sat <= !tv[26] && (tv[25:20] != '0);
			end
		end

		for (genvar i = 1; i <= 16; i++) begin : g_ex
			localparam logic [30:0] FAC = gspc_pkg::exp_factor(i);
			logic [61:0] mp;
			gspc_pkg::ex_t nx;
			assign mp = 62'(ex_s[g][i-1].mant) * 62'(FAC);
			always_comb begin
				nx = ex_s[g][i-1];
				if (ex_s[g][i-1].f[16-i]) begin
					nx.mant = mp[60:30];
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					ex_s[g][i] <= nx;
				end
			end
		end

		logic [46:0] shl;
		assign shl = 47'(ex_s[g][16].mant) << ex_s[g][16].k;
		assign sat_g[g] = ex_s[g][16].sat;
		assign ppm[g] = ex_s[g][16].sat ? 16'hFFFF
			: (ex_s[g][16].neg ? 16'h0000 : shl[45:30]);
	end

	logic [15:0] lpg_q, co_q, smoke_q;
	logic [1:0] status_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_q[NSTAGE-2]) begin
				lpg_q <= '0;
				co_q <= '0;
				smoke_q <= '0;
				status_q <= gspc_pkg::ST_ZERO;
			end else begin
				lpg_q <= ppm[0];
				co_q <= ppm[1];
				smoke_q <= ppm[2];
				status_q <= (sat_g != '0) ? gspc_pkg::ST_SAT : gspc_pkg::ST_OK;
			end
		end
	end

	assign out_valid = vld_q[NSTAGE-1];
	assign lpg_ppm = lpg_q;
	assign co_ppm = co_q;
	assign smoke_ppm = smoke_q;
	assign status = status_q;

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gspc_pkg::ST_ZERO |->
			lpg_ppm == '0 && co_ppm == '0 && smoke_ppm == '0)
		else $error("zero sample word carries nonzero ppm");
	a_sat_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gspc_pkg::ST_SAT |->
			lpg_ppm == 16'hFFFF || co_ppm == 16'hFFFF || smoke_ppm == 16'hFFFF)
		else $error("saturation status without a saturated ppm");
	a_ok_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gspc_pkg::ST_OK |-> !zero_q[NSTAGE-1])
		else $error("zero sample reported as ok");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

endmodule
`default_nettype wire
